[sv/igv_pkg.sv]
`timescale 1ns / 1ps
package igv_pkg;

  // Fixed formats of the sample fields
  localparam int NORMAL_FRAC  = 12;
  localparam int UNIFORM_FRAC = 16;
  localparam int NORM_LIMIT   = 30;

  // Pipelined unit depths, one bit or one root digit per stage
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 32;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SAT     = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic [31:0] VARIATE_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0]        mean_value;
    logic [31:0]        shape_value;
    logic signed [15:0] normal_sample;
    logic [15:0]        uniform_sample;
  } in_t;

  typedef struct packed {
    logic [31:0] variate;
    logic [1:0]  status;
  } out_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
  } sqrt_acc_t;

  typedef struct packed {
    logic [32:0] rem;
    logic        qbit;
  } div_acc_t;

  // One digit of the restoring square root: bring in two radicand bits
  function automatic sqrt_acc_t sqrt_step(logic [33:0] rem, logic [31:0] root,
                                          logic [1:0] bits);
    logic [35:0] remsh;
    logic [35:0] trial;
    sqrt_acc_t   r;
    remsh = {rem, bits};
    trial = {2'b00, root, 2'b01};
    if (remsh >= trial) begin
      r.rem  = 34'(remsh - trial);
      r.root = {root[30:0], 1'b1};
    end else begin
      r.rem  = remsh[33:0];
      r.root = {root[30:0], 1'b0};
    end
    return r;
  endfunction

  // One bit of restoring division
  function automatic div_acc_t div_step(logic [32:0] rem, logic [32:0] dsr, logic bit_in);
    logic [33:0] remsh;
    div_acc_t    r;
    remsh = {rem, bit_in};
    if (remsh >= {1'b0, dsr}) begin
      r.rem  = 33'(remsh - {1'b0, dsr});
      r.qbit = 1'b1;
    end else begin
      r.rem  = remsh[32:0];
      r.qbit = 1'b0;
    end
    return r;
  endfunction

endpackage

[sv/igv_sqrt.sv]
`timescale 1ns / 1ps
module igv_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [63:0] radicand,
  output logic        out_valid,
  output logic [31:0] root
);
  import igv_pkg::*;

  logic              valid [SQRT_STEPS];
  logic [33:0]       rem   [SQRT_STEPS];
  logic [31:0]       acc   [SQRT_STEPS];
  logic [63:0]       rad   [SQRT_STEPS];
  sqrt_acc_t         step  [SQRT_STEPS];

  // Compute each stage's digit from the stage before it
  always_comb begin
    step[0] = sqrt_step(34'd0, 32'd0, radicand[63:62]);
    for (int j = 1; j < SQRT_STEPS; j++) begin
      step[j] = sqrt_step(rem[j-1], acc[j-1], rad[j-1][63:62]);
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < SQRT_STEPS; j++) valid[j] <= 1'b0;
    end else begin
      valid[0] <= in_valid;
      for (int j = 1; j < SQRT_STEPS; j++) valid[j] <= valid[j-1];
    end
  end

  // Advance partial root, remainder and radicand
  always_ff @(posedge clk) begin
    rem[0] <= step[0].rem;
    acc[0] <= step[0].root;
    rad[0] <= {radicand[61:0], 2'b00};
    for (int j = 1; j < SQRT_STEPS; j++) begin
      rem[j] <= step[j].rem;
      acc[j] <= step[j].root;
      rad[j] <= {rad[j-1][61:0], 2'b00};
    end
  end

  assign out_valid = valid[SQRT_STEPS-1];
  assign root      = acc[SQRT_STEPS-1];

endmodule

[sv/igv_div.sv]
`timescale 1ns / 1ps
module igv_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [63:0] dividend,
  input  logic [32:0] divisor,
  output logic        out_valid,
  output logic [31:0] quotient
);
  import igv_pkg::*;

  logic        valid [DIV_STEPS];
  logic [32:0] rem   [DIV_STEPS];
  logic [31:0] quo   [DIV_STEPS];
  logic [31:0] low   [DIV_STEPS];
  logic [32:0] dsr   [DIV_STEPS];
  div_acc_t    step  [DIV_STEPS];

  // Start from the upper half, which the user must keep below the divisor; the block does not enforce it
  always_comb begin
    step[0] = div_step({1'b0, dividend[63:32]}, divisor, dividend[31]);
    for (int j = 1; j < DIV_STEPS; j++) begin
      step[j] = div_step(rem[j-1], dsr[j-1], low[j-1][31]);
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < DIV_STEPS; j++) valid[j] <= 1'b0;
    end else begin
      valid[0] <= in_valid;
      for (int j = 1; j < DIV_STEPS; j++) valid[j] <= valid[j-1];
    end
  end

  // Shift in one quotient bit per stage
  always_ff @(posedge clk) begin
    rem[0] <= step[0].rem;
    quo[0] <= {31'd0, step[0].qbit};
    low[0] <= {dividend[30:0], 1'b0};
    dsr[0] <= divisor;
    for (int j = 1; j < DIV_STEPS; j++) begin
      rem[j] <= step[j].rem;
      quo[j] <= {quo[j-1][30:0], step[j].qbit};
      low[j] <= {low[j-1][30:0], 1'b0};
      dsr[j] <= dsr[j-1];
    end
  end

  assign out_valid = valid[DIV_STEPS-1];
  assign quotient  = quo[DIV_STEPS-1];

endmodule

[sv/inverse_gaussian_variate_top.sv]
`timescale 1ns / 1ps
// Inverse Gaussian variate generator (Michael-Schucany-Haas transform).
// Input channel: drive request (mean, shape, normal and uniform draws) and
// raise start; the transaction is taken at a rising edge with start high and
// busy low. busy is always low: the pipeline takes one transaction per cycle.
// Output channel: done is high for exactly one cycle with result (variate,
// status) valid; the receiver must take it in that cycle and cannot stall.
// One result per accepted transaction, in order. Throughput is one transaction
// per cycle. The depth comes from three units in line, one bit or digit per
// stage: a 32-stage square root and two 32-stage restoring dividers (root x
// and mu*mu/x), plus a short normalize and multiply front end and the accept
// test.
// Reset clears all valid bits; transactions in flight are dropped and no
// done pulse follows until new transactions are accepted.
// Zero mean or shape gives variate 0, status 2; overflow saturates with
// status 1.
module inverse_gaussian_variate_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  igv_pkg::in_t  request,
  output logic          done,
  output igv_pkg::out_t result
);
  import igv_pkg::*;

  typedef struct packed {
    logic [31:0] mu;
    logic [15:0] u;
    logic        inv;
  } side_t;

  typedef struct packed {
    logic [31:0] mu;
    logic [15:0] u;
    logic        inv;
    logic        denz;
  } side2_t;

  typedef struct packed {
    logic [31:0] x;
    logic        inv;
    logic        acc;
    logic        sat;
  } side3_t;

  assign busy = 1'b0;

  // Stage A: capture, flag zero parameters, square the normal draw
  logic        va;
  side_t       sa;
  logic [31:0] lam_a;
  logic [30:0] y_a;
  logic [15:0] mag;
  assign mag = request.normal_sample[15] ? 16'(16'd0 - $unsigned(request.normal_sample))
                                         : $unsigned(request.normal_sample);
  always_ff @(posedge clk) begin
    sa.mu  <= request.mean_value;
    sa.u   <= request.uniform_sample;
    sa.inv <= (request.mean_value == 32'd0) || (request.shape_value == 32'd0);
    lam_a  <= request.shape_value;
    y_a    <= 31'(mag * mag);
  end

  // Stage B: s = mu*y, L = lambda at the scale of y
  logic        vb;
  side_t       sb;
  logic [61:0] s_b;
  logic [55:0] l_b;
  always_ff @(posedge clk) begin
    sb  <= sa;
    s_b <= 62'(sa.mu * y_a);
    l_b <= {lam_a, (2 * NORMAL_FRAC)'(0)};
  end

  // Stage C: larger operand, per-byte leading one
  logic        vc;
  side_t       sc;
  logic [61:0] s_c;
  logic [55:0] l_c;
  logic [7:0]  nz_c;
  logic [2:0]  lead_c [8];
  logic [63:0] big;
  logic [2:0]  lead_n [8];
  always_comb begin
    big = (s_b > {6'd0, l_b}) ? {2'b00, s_b} : {8'd0, l_b};
    for (int c = 0; c < 8; c++) begin
      lead_n[c] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (big[8*c+b]) lead_n[c] = 3'(b);
      end
    end
  end
  always_ff @(posedge clk) begin
    sc  <= sb;
    s_c <= s_b;
    l_c <= l_b;
    for (int c = 0; c < 8; c++) begin
      nz_c[c]   <= |big[8*c +: 8];
      lead_c[c] <= lead_n[c];
    end
  end

  // Stage D: bit length and normalizing shift
  logic        vd;
  side_t       sd;
  logic [61:0] s_d;
  logic [55:0] l_d;
  logic [5:0]  k_d;
  logic [6:0]  bl;
  always_comb begin
    bl = 7'd0;
    for (int c = 0; c < 8; c++) begin
      if (nz_c[c]) bl = 7'(8 * c) + {4'd0, lead_c[c]} + 7'd1;
    end
  end
  always_ff @(posedge clk) begin
    sd  <= sc;
    s_d <= s_c;
    l_d <= l_c;
    k_d <= (bl > 7'(NORM_LIMIT)) ? 6'(bl - 7'(NORM_LIMIT)) : 6'd0;
  end

  // Stage E: shift both operands down
  logic        ve;
  side_t       se;
  logic [29:0] s_e;
  logic [29:0] l_e;
  logic [61:0] s_sh;
  logic [55:0] l_sh;
  assign s_sh = s_d >> k_d;
  assign l_sh = l_d >> k_d;
  always_ff @(posedge clk) begin
    se  <= sd;
    s_e <= s_sh[29:0];
    l_e <= l_sh[29:0];
  end

  // Stage F: s' + 4L'
  logic        vf;
  side_t       sf;
  logic [29:0] s_f;
  logic [32:0] sum_f;
  always_ff @(posedge clk) begin
    sf    <= se;
    s_f   <= s_e;
    sum_f <= {3'd0, s_e} + {1'b0, l_e, 2'b00};
  end

  // Stage G: radicand s'*(s' + 4L')
  logic        vg;
  side_t       sg;
  logic [29:0] s_g;
  logic [63:0] p_g;
  always_ff @(posedge clk) begin
    sg  <= sf;
    s_g <= s_f;
    p_g <= 64'(s_f * sum_f);
  end

  // Square root, side data delayed alongside
  logic        vq;
  logic [31:0] q_root;
  side_t       sq_side [SQRT_STEPS];
  logic [29:0] sq_s    [SQRT_STEPS];
  igv_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vg),
    .radicand (p_g),
    .out_valid(vq),
    .root     (q_root)
  );
  always_ff @(posedge clk) begin
    sq_side[0] <= sg;
    sq_s[0]    <= s_g;
    for (int j = 1; j < SQRT_STEPS; j++) begin
      sq_side[j] <= sq_side[j-1];
      sq_s[j]    <= sq_s[j-1];
    end
  end

  // Stage H: numerator and denominator of the root ratio
  logic        vh;
  side_t       sh;
  logic [32:0] den_h;
  logic [31:0] num_h;
  always_ff @(posedge clk) begin
    sh    <= sq_side[SQRT_STEPS-1];
    den_h <= {1'b0, q_root} + {3'd0, sq_s[SQRT_STEPS-1]};
    num_h <= q_root - {2'd0, sq_s[SQRT_STEPS-1]};
  end

  // Stage I: mu*num
  logic        vi;
  side2_t      si;
  logic [32:0] den_i;
  logic [63:0] prod_i;
  always_ff @(posedge clk) begin
    si.mu   <= sh.mu;
    si.u    <= sh.u;
    si.inv  <= sh.inv;
    si.denz <= (den_h == 33'd0);
    den_i   <= den_h;
    prod_i  <= sh.mu * num_h;
  end

  // Smaller root x = mu*num/den
  logic        vx;
  logic [31:0] x_quo;
  side2_t      d1_side [DIV_STEPS];
  igv_div u_div_root (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vi),
    .dividend (prod_i),
    .divisor  (den_i),
    .out_valid(vx),
    .quotient (x_quo)
  );
  always_ff @(posedge clk) begin
    d1_side[0] <= si;
    for (int j = 1; j < DIV_STEPS; j++) d1_side[j] <= d1_side[j-1];
  end

  // Stage J: pick mu for a vanishing normal draw
  logic        vj;
  side_t       sj;
  logic [31:0] x_j;
  always_ff @(posedge clk) begin
    sj.mu  <= d1_side[DIV_STEPS-1].mu;
    sj.u   <= d1_side[DIV_STEPS-1].u;
    sj.inv <= d1_side[DIV_STEPS-1].inv;
    x_j    <= d1_side[DIV_STEPS-1].denz ? d1_side[DIV_STEPS-1].mu : x_quo;
  end

  // Stage K: u*(x+mu) and mu*mu
  logic        vk;
  side_t       sk;
  logic [31:0] x_k;
  logic [48:0] lhs_k;
  logic [63:0] mm_k;
  always_ff @(posedge clk) begin
    sk    <= sj;
    x_k   <= x_j;
    lhs_k <= 49'(sj.u * ({1'b0, x_j} + {1'b0, sj.mu}));
    mm_k  <= sj.mu * sj.mu;
  end

  // Stage L: accept test and overflow test
  logic        vl;
  side3_t      sl;
  logic [63:0] mm_l;
  always_ff @(posedge clk) begin
    sl.x   <= x_k;
    sl.inv <= sk.inv;
    sl.acc <= lhs_k < {1'b0, sk.mu, UNIFORM_FRAC'(0)};
    sl.sat <= mm_k[63:32] >= x_k;
    mm_l   <= mm_k;
  end

  // Reciprocal branch mu*mu/x
  logic        vr;
  logic [31:0] r_quo;
  side3_t      d2_side [DIV_STEPS];
  igv_div u_div_recip (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vl),
    .dividend (mm_l),
    .divisor  ({1'b0, sl.x}),
    .out_valid(vr),
    .quotient (r_quo)
  );
  always_ff @(posedge clk) begin
    d2_side[0] <= sl;
    for (int j = 1; j < DIV_STEPS; j++) d2_side[j] <= d2_side[j-1];
  end

  // Stage M: select the result
  side3_t fin;
  assign fin = d2_side[DIV_STEPS-1];
  always_ff @(posedge clk) begin
    priority if (fin.inv) begin
      result.variate <= 32'd0;
      result.status  <= ST_INVALID;
    end else if (fin.acc) begin
      result.variate <= fin.x;
      result.status  <= ST_OK;
    end else if (fin.sat) begin
      result.variate <= VARIATE_MAX;
      result.status  <= ST_SAT;
    end else begin
      result.variate <= r_quo;
      result.status  <= ST_OK;
    end
  end

  // Advance valid bits of the front end and tail
  always_ff @(posedge clk) begin
    if (rst) begin
      va   <= 1'b0;
      vb   <= 1'b0;
      vc   <= 1'b0;
      vd   <= 1'b0;
      ve   <= 1'b0;
      vf   <= 1'b0;
      vg   <= 1'b0;
      vh   <= 1'b0;
      vi   <= 1'b0;
      vj   <= 1'b0;
      vk   <= 1'b0;
      vl   <= 1'b0;
      done <= 1'b0;
    end else begin
      va   <= start;
      vb   <= va;
      vc   <= vb;
      vd   <= vc;
      ve   <= vd;
      vf   <= ve;
      vg   <= vf;
      vh   <= vq;
      vi   <= vh;
      vj   <= vx;
      vk   <= vj;
      vl   <= vk;
      done <= vr;
    end
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import igv_pkg::*;

  // Expected-result store and comparison for the variate stream
  class variate_scoreboard;
    out_t expected_q[$];
    int   mismatches;

    // Integer square root by the digit-pair method
    function automatic logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // Compute the variate that one transaction must produce
    function automatic out_t predict_variate(in_t req);
      out_t        o;
      logic [63:0] mu, lam, mag, y, s, shp, big, q, den, x, res;
      int          bl, k;
      mu  = 64'(req.mean_value);
      lam = 64'(req.shape_value);
      if (mu == 0 || lam == 0) begin
        o.variate = 32'd0;
        o.status  = ST_INVALID;
        return o;
      end
      mag = req.normal_sample[15] ? 64'h10000 - 64'(req.normal_sample[15:0])
                                  : 64'(req.normal_sample[15:0]);
      y   = mag * mag;
      s   = mu * y;
      shp = lam << (2 * NORMAL_FRAC);
      big = (s > shp) ? s : shp;
      bl = 0;
      while (big != 0) begin
        big = big >> 1;
        bl++;
      end
      k = (bl > NORM_LIMIT) ? bl - NORM_LIMIT : 0;
      s   = s >> k;
      shp = shp >> k;
      q   = root_floor(s * (s + 4 * shp));
      den = q + s;
      if (den == 0) x = mu;
      else x = (mu * (q - s)) / den;
      // Keep the smaller root when the uniform draw accepts it
      if (64'(req.uniform_sample) * (x + mu) < (mu << UNIFORM_FRAC)) begin
        o.variate = x[31:0];
        o.status  = ST_OK;
        return o;
      end
      if (x == 0) begin
        o.variate = VARIATE_MAX;
        o.status  = ST_SAT;
        return o;
      end
      res = (mu * mu) / x;
      if (res > 64'(VARIATE_MAX)) begin
        o.variate = VARIATE_MAX;
        o.status  = ST_SAT;
      end else begin
        o.variate = res[31:0];
        o.status  = ST_OK;
      end
      return o;
    endfunction

    function void note_request(in_t req);
      expected_q.push_back(predict_variate(req));
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h/%0d", got.variate, got.status);
        return;
      end
      want = expected_q.pop_front();
      if (got.variate !== want.variate || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %h/%0d actual %h/%0d",
                   want.variate, want.status, got.variate, got.status);
      end
    endfunction
  endclass

  logic  clk;
  logic  rst;
  logic  start;
  logic  busy;
  in_t   request;
  logic  done;
  out_t  result;
  int    cycles = 0;
  variate_scoreboard board;

  inverse_gaussian_variate_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request(request), .done(done), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Take results and accepted transactions at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) board.note_request(request);
      if (done) board.check_result(result);
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Drive one transaction, after a random gap if allowed, hold it until accepted
  task automatic send_request(in_t req, bit allow_gap);
    int gap;
    gap = allow_gap ? $urandom_range(0, 11) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    request <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic in_t make_request(logic [31:0] mu, logic [31:0] lam,
                                       logic [15:0] nu, logic [15:0] u);
    in_t r;
    r.mean_value     = mu;
    r.shape_value    = lam;
    r.normal_sample  = nu;
    r.uniform_sample = u;
    return r;
  endfunction

  // Pick a value with a random magnitude so that small and huge both occur
  function automatic logic [31:0] rand_word();
    int sh;
    sh = $urandom_range(0, 31);
    return $urandom() >> sh;
  endfunction

  initial begin
    in_t req;
    int  settle;
    board   = new();
    rst     = 1'b1;
    start   = 1'b0;
    request = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: zero mean or shape, field extremes, vanishing draw, rejection
    send_request(make_request(32'd0, 32'h0001_0000, 16'h1000, 16'h8000), 1'b0);
    send_request(make_request(32'h0001_0000, 32'd0, 16'h1000, 16'h8000), 1'b0);
    send_request(make_request(32'd0, 32'd0, 16'h0000, 16'h0000), 1'b0);
    send_request(make_request(32'h0001_0000, 32'h0001_0000, 16'h0000, 16'h0000), 1'b0);
    send_request(make_request(32'h0001_0000, 32'h0001_0000, 16'h0000, 16'hFFFF), 1'b0);
    send_request(make_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h7FFF, 16'hFFFF), 1'b0);
    send_request(make_request(32'hFFFF_FFFF, 32'h0000_0001, 16'h8000, 16'hFFFF), 1'b0);
    send_request(make_request(32'hFFFF_FFFF, 32'h0000_0001, 16'h8000, 16'h0000), 1'b0);
    send_request(make_request(32'h0000_0001, 32'hFFFF_FFFF, 16'h0001, 16'hFFFF), 1'b0);
    send_request(make_request(32'h0000_0001, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000), 1'b0);
    send_request(make_request(32'h0100_0000, 32'h0000_0100, 16'h7FFF, 16'hFFFF), 1'b0);
    send_request(make_request(32'h0001_0000, 32'h0002_0000, 16'hF000, 16'h4000), 1'b0);
    send_request(make_request(32'h0001_0000, 32'h0002_0000, 16'hF000, 16'hC000), 1'b0);
    send_request(make_request(32'h8000_0000, 32'h0000_0010, 16'h4000, 16'hFFFF), 1'b0);
    send_request(make_request(32'hFFFF_FFFF, 32'h0000_0001, 16'h0001, 16'hFFFF), 1'b0);

    // Random: mostly plausible parameters, some raw extremes
    for (int i = 0; i < 700; i++) begin
      req.mean_value     = rand_word();
      req.shape_value    = rand_word();
      req.normal_sample  = 16'($urandom_range(0, 65535));
      req.uniform_sample = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 3) == 0)
        req.normal_sample = 16'($urandom_range(0, 12000) - 6000);
      if ($urandom_range(0, 40) == 0) req.mean_value = 32'd0;
      if ($urandom_range(0, 40) == 0) req.shape_value = 32'd0;
      send_request(req, (i % 100) < 70);
    end
    start <= 1'b0;

    // Drain the pipeline, then allow its latency
    while (board.expected_q.size() != 0) @(posedge clk);
    settle = 0;
    while (settle < 150) begin
      @(posedge clk);
      settle++;
    end
    if (board.mismatches == 0 && board.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
